### design/dhts_pkg.sv
// Shared constants, types and helper functions for the double-hashing table.
// Used by every module of the block; depends on nothing else.
package dhts_pkg;

  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned KEY_W       = 24;
  localparam int unsigned HASH_MUL    = 11;
  localparam int unsigned PROD_W      = KEY_W + 4;
  localparam int unsigned IDX_W       = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned MOD_W       = IDX_W + 1;

  localparam int unsigned     DVD_W     = PROD_W;
  localparam int unsigned     RECIP_W   = PROD_W + 1;
  localparam longint unsigned RECIP_ONE = 64'd1 << PROD_W;

  localparam logic [RECIP_W-1:0] RECIP_SLOTS = RECIP_W'(RECIP_ONE / 64'(TABLE_SLOTS));
  localparam logic [RECIP_W-1:0] RECIP_STEP  = RECIP_W'(RECIP_ONE / 64'(TABLE_SLOTS - 1));

  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CNT_MAX    = 31;
  localparam int unsigned CNT_EXT_W  = (MOD_W > CNT_W) ? MOD_W : CNT_W;
  localparam int unsigned SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
  } tbl_wr_t;

  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_EXT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v > CNT_EXT_W'(CNT_MAX)) begin
      r = CNT_W'(CNT_MAX);
    end else begin
      r = v[CNT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] p);
    logic [SLOT_EXT_W-1:0] t;
    t = SLOT_EXT_W'(p);
    return t[SLOT_W-1:0];
  endfunction

endpackage

### design/dhts_mod_unit.sv
// Shared modulo reduction unit: reciprocal multiply for the quotient, then multiply
// back and one correction step; operands, quotient and remainder register in turn.
// Depends on dhts_pkg.
module dhts_mod_unit
  import dhts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [MOD_W-1:0]   modulus_i,
  input  logic [RECIP_W-1:0] recip_i,
  output logic               done_o,
  output logic [IDX_W-1:0]   rem_o
);

  logic                     busy_q;
  logic                     calc_q;
  logic                     done_q;
  logic [DVD_W-1:0]         dvd_q;
  logic [MOD_W-1:0]         mod_q;
  logic [RECIP_W-1:0]       recip_q;
  logic [DVD_W+RECIP_W-1:0] prod;
  logic [MOD_W-1:0]         quo_q;
  logic [MOD_W-1:0]         quo_d;
  logic [MOD_W-1:0]         rem_q;
  logic [MOD_W-1:0]         rem_d;

  assign prod  = {{RECIP_W{1'b0}}, dvd_q} * {{DVD_W{1'b0}}, recip_q};
  assign quo_d = prod[DVD_W +: MOD_W];

  always_comb begin
    logic [2*MOD_W-1:0] qd;
    logic [MOD_W-1:0]   r;
    qd = {{MOD_W{1'b0}}, quo_q} * {{MOD_W{1'b0}}, mod_q};
    r  = dvd_q[MOD_W-1:0] - qd[MOD_W-1:0];
    if (r >= mod_q) begin
      r = r - mod_q;
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      calc_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      calc_q <= busy_q;
      done_q <= calc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q   <= dividend_i;
      mod_q   <= modulus_i;
      recip_q <= recip_i;
    end
    if (busy_q) begin
      quo_q <= quo_d;
    end
    if (calc_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule

### design/dhts_table.sv
// Slot storage: key memory with registered read and reset-cleared occupancy bits.
// Depends on dhts_pkg.
module dhts_table
  import dhts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  logic [IDX_W-1:0] used_addr_i,
  input  tbl_wr_t          wr_i,
  output logic [KEY_W-1:0] rd_key_o,
  output logic             used_o
);

  logic [KEY_W-1:0]       mem_q [TABLE_SLOTS];
  logic [KEY_W-1:0]       rd_key_q;
  logic [TABLE_SLOTS-1:0] used_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.key;
    end
    rd_key_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.en) begin
      used_q[wr_i.addr] <= 1'b1;
    end
  end

  assign rd_key_o = rd_key_q;
  assign used_o   = used_q[used_addr_i];

endmodule

### design/double_hash_table_insert_search.sv
// Open-addressing hash table with double hashing; insert or search one key per word.
// A new word is accepted only while the block is idle, after the response to the last
// word has been moved into the output register; each word takes two passes of the
// shared modulo unit, then one probe per cycle with up to TABLE_SLOTS probes; a held
// output word stalls the response and so the input.
// Reset clears every occupancy bit at once; the key memory is not cleared.
module double_hash_table_insert_search
  import dhts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key[23:0]
  input  logic                  s_axis_tuser,  // mode[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // slot[3:0], probe_count[8:4], zeros
  output logic [STATUS_W-1:0]   m_axis_tuser   // status[1:0]
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH1 = 3'd1;
  localparam logic [2:0] S_HASH2 = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                search_q, search_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [IDX_W-1:0]    first_q, first_d;
  logic [IDX_W-1:0]    step_q, step_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [CNT_W-1:0]    res_cnt_q, res_cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [CNT_W-1:0]    out_cnt_q, out_cnt_d;

  logic                mod_start;
  logic [DVD_W-1:0]    mod_dvd;
  logic [MOD_W-1:0]    mod_m;
  logic [RECIP_W-1:0]  mod_recip;
  logic                mod_done;
  logic [IDX_W-1:0]    mod_rem;
  logic [MOD_W-1:0]    pos_sum;
  logic [MOD_W-1:0]    pos_adv;
  logic [KEY_W-1:0]    rd_key;
  logic                used;
  tbl_wr_t             wr;

  dhts_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .modulus_i  (mod_m),
    .recip_i    (mod_recip),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  dhts_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (pos_d),
    .used_addr_i (pos_q),
    .wr_i        (wr),
    .rd_key_o    (rd_key),
    .used_o      (used)
  );

  assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};
  assign pos_adv = (pos_sum >= MOD_W'(TABLE_SLOTS)) ? (pos_sum - MOD_W'(TABLE_SLOTS)) : pos_sum;

  always_comb begin
    state_d      = state_q;
    search_d     = search_q;
    key_d        = key_q;
    first_d      = first_q;
    step_d       = step_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_cnt_d    = res_cnt_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_cnt_d    = out_cnt_q;
    mod_start    = 1'b0;
    mod_dvd      = '0;
    mod_m        = MOD_W'(TABLE_SLOTS);
    mod_recip    = RECIP_SLOTS;
    wr           = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          search_d  = s_axis_tuser;
          key_d     = s_axis_tdata[KEY_W-1:0];
          mod_start = 1'b1;
          mod_dvd   = DVD_W'(PROD_W'(s_axis_tdata[KEY_W-1:0]) * PROD_W'(HASH_MUL));
          state_d   = S_HASH1;
        end
      end
      S_HASH1: begin
        if (mod_done) begin
          first_d   = mod_rem;
          mod_start = 1'b1;
          mod_dvd   = DVD_W'(key_q);
          mod_m     = MOD_W'(TABLE_SLOTS - 1);
          mod_recip = RECIP_STEP;
          state_d   = S_HASH2;
        end
      end
      S_HASH2: begin
        if (mod_done) begin
          step_d  = mod_rem + IDX_W'(1);
          pos_d   = first_q;
          idx_d   = '0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!used) begin
          res_status_d = search_q ? ST_MISSING : ST_INSERTED;
          res_slot_d   = search_q ? '0 : slot_field(pos_q);
          res_cnt_d    = sat_count(CNT_EXT_W'(idx_q));
          wr.en        = !search_q;
          wr.addr      = pos_q;
          wr.key       = key_q;
          state_d      = S_RESP;
        end else if (search_q && (rd_key == key_q)) begin
          res_status_d = ST_FOUND;
          res_slot_d   = slot_field(pos_q);
          res_cnt_d    = sat_count(CNT_EXT_W'(idx_q));
          state_d      = S_RESP;
        end else if (idx_q == IDX_W'(TABLE_SLOTS - 1)) begin
          res_status_d = search_q ? ST_MISSING : ST_FULL;
          res_slot_d   = '0;
          res_cnt_d    = sat_count(CNT_EXT_W'(TABLE_SLOTS));
          state_d      = S_RESP;
        end else begin
          pos_d = pos_adv[IDX_W-1:0];
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_cnt_d    = res_cnt_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    search_q     <= search_d;
    key_q        <= key_d;
    first_q      <= first_d;
    step_q       <= step_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_cnt_q    <= res_cnt_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OUT_DATA_W - CNT_W - SLOT_W)'(0), out_cnt_q, out_slot_q};

`ifndef SYNTHESIS
  a_mod_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_HASH1 || state_q == S_HASH2))
    else $error("Modulo unit finished outside the hashing states.");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (step_q != '0 && {1'b0, step_q} < MOD_W'(TABLE_SLOTS)))
    else $error("Probe step is zero or not below the table size.");

  a_accept_starts_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == S_HASH1 && !mod_done))
    else $error("Accepted word did not start the first hash pass.");
`endif

endmodule
